FILE: rtl/core/cpsm_pkg.sv
// Package for the cluster point symmetry match core: item and stage types,
// widths, rotation table and configuration register indexes. No dependencies.
`timescale 1ns / 1ps

package cpsm_pkg;

  localparam int MAX_OPS    = 24;
  localparam int MAX_PTS    = 4;
  localparam int PROPER_OPS = 12;

  localparam int CW  = 18;  // Q7.10 coordinate
  localparam int CIW = 19;  // centred coordinate
  localparam int PW  = 34;  // centred value times a Q1.14 coefficient
  localparam int AW  = 36;  // rotation row accumulator
  localparam int TW  = 22;  // rotated, rounded coordinate
  localparam int EW  = 24;  // pair difference
  localparam int DW  = 48;  // squared distance
  localparam int TOLW = 24;

  localparam int Q1 = 16384;
  localparam int QH = 8192;
  localparam int QR = 14189;
  localparam int ROUND_SHIFT = 14;

  localparam logic [TOLW-1:0] TOL_RESET = 24'd94372;

  typedef enum logic [2:0] {
    CFG_REF_POINT_0 = 3'd0,
    CFG_REF_POINT_1 = 3'd1,
    CFG_REF_POINT_2 = 3'd2,
    CFG_REF_POINT_3 = 3'd3,
    CFG_MATCH_TOL   = 3'd4
  } cfg_idx_e;

  // proper rotations, row-major; operations 12..23 are these with inversion
  localparam int ROT_ROM [PROPER_OPS][9] = '{
    '{ Q1,   0, 0,    0,  Q1, 0,   0, 0,  Q1},
    '{-QH, -QR, 0,   QR, -QH, 0,   0, 0,  Q1},
    '{-QH,  QR, 0,  -QR, -QH, 0,   0, 0,  Q1},
    '{-Q1,   0, 0,    0, -Q1, 0,   0, 0,  Q1},
    '{ QH,  QR, 0,  -QR,  QH, 0,   0, 0,  Q1},
    '{ QH, -QR, 0,   QR,  QH, 0,   0, 0,  Q1},
    '{-QH,  QR, 0,   QR,  QH, 0,   0, 0, -Q1},
    '{ Q1,   0, 0,    0, -Q1, 0,   0, 0, -Q1},
    '{-QH, -QR, 0,  -QR,  QH, 0,   0, 0, -Q1},
    '{ QH, -QR, 0,  -QR, -QH, 0,   0, 0, -Q1},
    '{-Q1,   0, 0,    0,  Q1, 0,   0, 0, -Q1},
    '{ QH,  QR, 0,   QR, -QH, 0,   0, 0, -Q1}
  };

  typedef struct packed {
    logic [57:0] atom_0;
    logic [57:0] atom_1;
    logic [57:0] atom_2;
    logic [57:0] atom_3;
  } in_item_t;

  typedef struct packed {
    logic [23:0] valid_mask;
    logic [4:0]  match_cnt;
  } out_item_t;

  // c[0] = x, c[1] = y, c[2] = z
  typedef struct packed {
    logic [2:0][CW-1:0] c;
    logic [3:0]         sp;
  } atom_t;

  typedef struct packed {
    logic [MAX_PTS-1:0][2:0][CIW-1:0] ci;  // input atoms minus input mean
    logic [MAX_PTS-1:0][2:0][CIW-1:0] d;   // reference atoms minus reference mean
    logic [MAX_PTS-1:0][2:0][PW-1:0]  pr;  // d times QR
    logic [MAX_PTS-1:0][3:0]          csp;
    logic [MAX_PTS-1:0][3:0]          rsp;
  } prep_t;

  typedef struct packed {
    logic [MAX_PTS-1:0][2:0][CIW-1:0]             ci;
    logic [PROPER_OPS-1:0][MAX_PTS-1:0][2:0][TW-1:0] tr;
    logic [MAX_PTS-1:0][3:0]                      csp;
    logic [MAX_PTS-1:0][3:0]                      rsp;
  } rot_t;

  // hit[k][i][j]: input atom i lies near transformed reference atom j under op k
  typedef logic [MAX_OPS-1:0][MAX_PTS-1:0][MAX_PTS-1:0] hit_t;

  function automatic atom_t unpack_atom(input logic [57:0] w);
    atom_t a;
    a.c[0] = w[57:40];
    a.c[1] = w[39:22];
    a.c[2] = w[21:4];
    a.sp   = w[3:0];
    return a;
  endfunction

endpackage

FILE: rtl/core/cluster_point_symmetry_match_core.sv
// Top level of the cluster point symmetry match core: configuration registers
// and the five-stage pipeline. Uses cpsm_pkg and the cpsm_* stage modules.
//
// Usage:
//   Input: raise start with a four-atom cluster on item_i. busy is always low,
//   so an item is taken at every clock edge where start is high.
//   Output: result_valid_o pulses for one cycle with the match mask and count
//   of one item. Results come out in input order and cannot be held off.
//   Throughput: one item per cycle; the stages are unrolled over all
//   operations and atom pairs, so nothing is shared between items.
//   Stages: input/means, centring and QR products, rotation, squared
//   distances against the tolerance, greedy pairing and count.
//   Configuration: cfg_we_i writes register cfg_idx_i (0..3 reference atoms,
//   4 tolerance); other indexes are dropped. Write only while idle.
//   Reset: reference atoms clear to zero, tolerance to 0.3 squared, and the
//   pipeline drops all items in flight.
`timescale 1ns / 1ps

module cluster_point_symmetry_match_core #(
  parameter int OPERATIONS     = cpsm_pkg::MAX_OPS,
  parameter int CLUSTER_POINTS = cpsm_pkg::MAX_PTS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  cpsm_pkg::in_item_t  item_i,
  output logic                result_valid_o,
  output cpsm_pkg::out_item_t result_o,
  input  logic                cfg_we_i,
  input  logic [2:0]          cfg_idx_i,
  input  logic [57:0]         cfg_data_i
);

  localparam int NOPS = (OPERATIONS > cpsm_pkg::MAX_OPS) ? cpsm_pkg::MAX_OPS : OPERATIONS;
  localparam int NPTS = (CLUSTER_POINTS > cpsm_pkg::MAX_PTS) ? cpsm_pkg::MAX_PTS
                                                             : CLUSTER_POINTS;

  logic [cpsm_pkg::MAX_PTS-1:0][57:0]     ref_q;
  logic [cpsm_pkg::TOLW-1:0]              tol_q;
  cpsm_pkg::atom_t [cpsm_pkg::MAX_PTS-1:0] ref_atoms;

  logic            prep_vld, rot_vld, dist_vld;
  cpsm_pkg::prep_t prep_data;
  cpsm_pkg::rot_t  rot_data;
  cpsm_pkg::hit_t  hit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_q <= '0;
      tol_q <= cpsm_pkg::TOL_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        cpsm_pkg::CFG_REF_POINT_0: ref_q[0] <= cfg_data_i;
        cpsm_pkg::CFG_REF_POINT_1: ref_q[1] <= cfg_data_i;
        cpsm_pkg::CFG_REF_POINT_2: ref_q[2] <= cfg_data_i;
        cpsm_pkg::CFG_REF_POINT_3: ref_q[3] <= cfg_data_i;
        cpsm_pkg::CFG_MATCH_TOL:   tol_q    <= cfg_data_i[cpsm_pkg::TOLW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < cpsm_pkg::MAX_PTS; i++) begin
      ref_atoms[i] = cpsm_pkg::unpack_atom(ref_q[i]);
    end
  end

  assign busy = 1'b0;

  cpsm_prep #(.NPTS(NPTS)) u_prep (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (start && !busy),
    .item_i (item_i),
    .ref_i  (ref_atoms),
    .vld_o  (prep_vld),
    .data_o (prep_data)
  );

  cpsm_rotate u_rotate (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (prep_vld),
    .data_i (prep_data),
    .vld_o  (rot_vld),
    .data_o (rot_data)
  );

  cpsm_dist #(.NOPS(NOPS), .NPTS(NPTS)) u_dist (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (rot_vld),
    .data_i (rot_data),
    .tol_i  (tol_q),
    .vld_o  (dist_vld),
    .hit_o  (hit)
  );

  cpsm_pair #(.NOPS(NOPS), .NPTS(NPTS)) u_pair (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (dist_vld),
    .hit_i  (hit),
    .vld_o  (result_valid_o),
    .res_o  (result_o)
  );

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##5 result_valid_o)
    else $error("accepted item produced no result after five cycles");

  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> (32'(result_o.match_cnt) == $countones(result_o.valid_mask)))
    else $error("match count disagrees with mask");

  a_mask_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> ((32'(result_o.valid_mask) >> NOPS) == 32'd0))
    else $error("mask bit set for an unused operation");

endmodule

FILE: rtl/core/cpsm_prep.sv
// Front stages: register the item, take both cluster means, centre the
// points and form the QR products. Uses cpsm_pkg.
`timescale 1ns / 1ps

module cpsm_prep #(
  parameter int NPTS = cpsm_pkg::MAX_PTS
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  vld_i,
  input  cpsm_pkg::in_item_t                    item_i,
  input  cpsm_pkg::atom_t [cpsm_pkg::MAX_PTS-1:0] ref_i,
  output logic                                  vld_o,
  output cpsm_pkg::prep_t                       data_o
);

  localparam int SW = cpsm_pkg::CW + 3;
  localparam int MSH = 22;
  localparam logic [MSH:0] MEAN_MUL = (MSH+1)'(((1 << MSH) + NPTS - 1) / NPTS);

  // floor(s / NPTS) by reciprocal; negative sums go through -floor((-s+N-1)/N)
  function automatic logic [cpsm_pkg::CW-1:0] mean_fn(input logic signed [SW-1:0] s);
    logic [SW-1:0]      t;
    logic [SW+MSH:0]    p;
    logic [SW-1:0]      q;
    logic [SW-1:0]      m;
    t = s[SW-1] ? SW'(-s + SW'(NPTS - 1)) : s;
    p = (SW+MSH+1)'(t) * (SW+MSH+1)'(MEAN_MUL);
    q = p[SW+MSH-1:MSH];
    m = s[SW-1] ? SW'(-q) : q;
    return m[cpsm_pkg::CW-1:0];
  endfunction

  cpsm_pkg::atom_t [cpsm_pkg::MAX_PTS-1:0] cl_in;
  cpsm_pkg::atom_t [cpsm_pkg::MAX_PTS-1:0] cl_q, ref_q;
  logic [2:0][cpsm_pkg::CW-1:0] ic_d, ic_q, rc_d, rc_q;
  logic v1_q, v2_q;
  cpsm_pkg::prep_t p_d, p_q;

  assign cl_in[0] = cpsm_pkg::unpack_atom(item_i.atom_0);
  assign cl_in[1] = cpsm_pkg::unpack_atom(item_i.atom_1);
  assign cl_in[2] = cpsm_pkg::unpack_atom(item_i.atom_2);
  assign cl_in[3] = cpsm_pkg::unpack_atom(item_i.atom_3);

  always_comb begin
    logic signed [SW-1:0] isum, rsum;
    for (int j = 0; j < 3; j++) begin
      isum = '0;
      rsum = '0;
      for (int i = 0; i < NPTS; i++) begin
        isum = isum + SW'($signed(cl_in[i].c[j]));
        rsum = rsum + SW'($signed(ref_i[i].c[j]));
      end
      ic_d[j] = mean_fn(isum);
      rc_d[j] = mean_fn(rsum);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= vld_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    cl_q  <= cl_in;
    ref_q <= ref_i;
    ic_q  <= ic_d;
    rc_q  <= rc_d;
    p_q   <= p_d;
  end

  always_comb begin
    logic signed [cpsm_pkg::CIW-1:0] dv;
    p_d = '0;
    for (int i = 0; i < cpsm_pkg::MAX_PTS; i++) begin
      p_d.csp[i] = cl_q[i].sp;
      p_d.rsp[i] = ref_q[i].sp;
      for (int j = 0; j < 3; j++) begin
        p_d.ci[i][j] = cpsm_pkg::CIW'($signed(cl_q[i].c[j])) -
                       cpsm_pkg::CIW'($signed(ic_q[j]));
        dv = cpsm_pkg::CIW'($signed(ref_q[i].c[j])) -
             cpsm_pkg::CIW'($signed(rc_q[j]));
        p_d.d[i][j]  = dv;
        p_d.pr[i][j] = cpsm_pkg::PW'(dv) * cpsm_pkg::PW'(cpsm_pkg::QR);
      end
    end
  end

  assign vld_o  = v2_q;
  assign data_o = p_q;

endmodule

FILE: rtl/core/cpsm_rotate.sv
// Rotation stage: applies the twelve proper rotation matrices to the centred
// reference points and rounds to Q.10. Uses cpsm_pkg.
`timescale 1ns / 1ps

module cpsm_rotate (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            vld_i,
  input  cpsm_pkg::prep_t data_i,
  output logic            vld_o,
  output cpsm_pkg::rot_t  data_o
);

  function automatic logic signed [cpsm_pkg::AW-1:0] term(
    input int coef,
    input logic signed [cpsm_pkg::CIW-1:0] d,
    input logic signed [cpsm_pkg::PW-1:0]  pr
  );
    logic signed [cpsm_pkg::AW-1:0] dx;
    logic signed [cpsm_pkg::AW-1:0] px;
    dx = cpsm_pkg::AW'(d);
    px = cpsm_pkg::AW'(pr);
    case (coef)
      cpsm_pkg::Q1:  return dx <<< 14;
      -cpsm_pkg::Q1: return -(dx <<< 14);
      cpsm_pkg::QH:  return dx <<< 13;
      -cpsm_pkg::QH: return -(dx <<< 13);
      cpsm_pkg::QR:  return px;
      -cpsm_pkg::QR: return -px;
      default:       return '0;
    endcase
  endfunction

  logic           v_q;
  cpsm_pkg::rot_t r_d, r_q;

  always_comb begin
    logic signed [cpsm_pkg::AW-1:0] acc;
    logic signed [cpsm_pkg::AW-1:0] sh;
    r_d     = '0;
    r_d.ci  = data_i.ci;
    r_d.csp = data_i.csp;
    r_d.rsp = data_i.rsp;
    for (int k = 0; k < cpsm_pkg::PROPER_OPS; k++) begin
      for (int i = 0; i < cpsm_pkg::MAX_PTS; i++) begin
        for (int r = 0; r < 3; r++) begin
          acc = cpsm_pkg::AW'(cpsm_pkg::QH);  // round half up
          for (int c = 0; c < 3; c++) begin
            acc = acc + term(cpsm_pkg::ROT_ROM[k][r*3+c], $signed(data_i.d[i][c]),
                             $signed(data_i.pr[i][c]));
          end
          sh = acc >>> cpsm_pkg::ROUND_SHIFT;
          r_d.tr[k][i][r] = sh[cpsm_pkg::TW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else begin
      v_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q <= r_d;
  end

  assign vld_o  = v_q;
  assign data_o = r_q;

endmodule

FILE: rtl/core/cpsm_dist.sv
// Distance stage: squared distance of every input/reference pair under every
// operation, compared with the tolerance. Uses cpsm_pkg.
`timescale 1ns / 1ps

module cpsm_dist #(
  parameter int NOPS = cpsm_pkg::MAX_OPS,
  parameter int NPTS = cpsm_pkg::MAX_PTS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         vld_i,
  input  cpsm_pkg::rot_t               data_i,
  input  logic [cpsm_pkg::TOLW-1:0]    tol_i,
  output logic                         vld_o,
  output cpsm_pkg::hit_t               hit_o
);

  logic           v_q;
  cpsm_pkg::hit_t h_d, h_q;

  always_comb begin
    logic signed [cpsm_pkg::EW-1:0]   e;
    logic signed [cpsm_pkg::EW-1:0]   t;
    logic signed [2*cpsm_pkg::EW-1:0] sq;
    logic [cpsm_pkg::DW-1:0]          dsq;
    h_d = '0;
    for (int k = 0; k < NOPS; k++) begin
      for (int i = 0; i < NPTS; i++) begin
        for (int j = 0; j < NPTS; j++) begin
          dsq = '0;
          for (int q = 0; q < 3; q++) begin
            t = cpsm_pkg::EW'($signed(data_i.tr[k % cpsm_pkg::PROPER_OPS][j][q]));
            e = cpsm_pkg::EW'($signed(data_i.ci[i][q]));
            // inversion negates the rotated point
            e = (k >= cpsm_pkg::PROPER_OPS) ? e + t : e - t;
            sq = e * e;
            dsq = dsq + cpsm_pkg::DW'(sq);
          end
          h_d[k][i][j] = (data_i.rsp[j] == data_i.csp[i]) &&
                         (dsq < cpsm_pkg::DW'(tol_i));
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else begin
      v_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    h_q <= h_d;
  end

  assign vld_o = v_q;
  assign hit_o = h_q;

endmodule

FILE: rtl/core/cpsm_pair.sv
// Pairing stage: greedy first-free pairing per operation, then the match mask
// and its population count into the result register. Uses cpsm_pkg.
`timescale 1ns / 1ps

module cpsm_pair #(
  parameter int NOPS = cpsm_pkg::MAX_OPS,
  parameter int NPTS = cpsm_pkg::MAX_PTS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                vld_i,
  input  cpsm_pkg::hit_t      hit_i,
  output logic                vld_o,
  output cpsm_pkg::out_item_t res_o
);

  logic                v_q;
  cpsm_pkg::out_item_t res_d, res_q;

  always_comb begin
    logic [cpsm_pkg::MAX_PTS-1:0] used;
    logic                         found;
    logic                         ok;
    res_d = '0;
    for (int k = 0; k < NOPS; k++) begin
      used = '0;
      ok   = 1'b1;
      for (int i = 0; i < NPTS; i++) begin
        found = 1'b0;
        for (int j = 0; j < NPTS; j++) begin
          if (!found && !used[j] && hit_i[k][i][j]) begin
            used[j] = 1'b1;
            found   = 1'b1;
          end
        end
        ok = ok & found;
      end
      res_d.valid_mask[k] = ok;
      res_d.match_cnt     = res_d.match_cnt + 5'(ok);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else begin
      v_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign vld_o = v_q;
  assign res_o = res_q;

endmodule

FILE: test/cluster_point_symmetry_match_core_tb.sv
// Self-checking testbench for cluster_point_symmetry_match_core: a directed table,
// then phases of random clusters under several register settings and idle rates.
// Depends on cpsm_pkg and the core RTL.
`timescale 1ns / 1ps

module cluster_point_symmetry_match_core_tb;
  import cpsm_pkg::*;

  localparam logic [2:0] CFG_IDX_UNUSED = 3'd6;
  localparam int LATENCY = 5;

  typedef struct {
    in_item_t  it;
    bit        known;
    out_item_t res;
  } table_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  in_item_t    item_i = '0;
  logic        result_valid_o;
  out_item_t   result_o;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = CFG_REF_POINT_0;
  logic [57:0] cfg_data_i = '0;

  // register mirror
  logic [57:0]     ref_atom [4];
  logic [TOLW-1:0] tol_sq;

  out_item_t  pending_results [$];
  int         fail_cnt = 0;
  int         idle_pct = 0;
  longint     img [4][3];

  cluster_point_symmetry_match_core u_dut (
    .clk_i, .rst_ni, .start, .busy, .item_i, .result_valid_o, .result_o,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  always #5 clk_i = ~clk_i;

  function automatic longint coord(logic [57:0] w, int j);
    case (j)
      0:       return longint'($signed(w[57:40]));
      1:       return longint'($signed(w[39:22]));
      default: return longint'($signed(w[21:4]));
    endcase
  endfunction

  // reference atoms centred, put through operation k, moved to the given centre
  function automatic void place_ref(int k, longint cx, longint cy, longint cz);
    longint rc [3];
    longint d [3];
    longint s;
    longint ctr [3];
    ctr[0] = cx; ctr[1] = cy; ctr[2] = cz;
    for (int j = 0; j < 3; j++) begin
      s = 0;
      for (int i = 0; i < 4; i++) s += coord(ref_atom[i], j);
      rc[j] = s >>> 2;
    end
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 3; j++) d[j] = coord(ref_atom[i], j) - rc[j];
      for (int j = 0; j < 3; j++) begin
        s = 0;
        for (int q = 0; q < 3; q++) s += longint'(ROT_ROM[k % 12][j*3+q]) * d[q];
        s = (s + 8192) >>> ROUND_SHIFT;
        if (k >= PROPER_OPS) s = -s;
        img[i][j] = s + ctr[j];
      end
    end
  endfunction

  function automatic out_item_t match_ops(in_item_t it);
    logic [57:0] a [4];
    longint      ic [3];
    longint      s, e, dsq;
    bit          used [4];
    bit          ok, found;
    out_item_t   r;
    a[0] = it.atom_0; a[1] = it.atom_1; a[2] = it.atom_2; a[3] = it.atom_3;
    for (int j = 0; j < 3; j++) begin
      s = 0;
      for (int i = 0; i < 4; i++) s += coord(a[i], j);
      ic[j] = s >>> 2;
    end
    r = '0;
    for (int k = 0; k < MAX_OPS; k++) begin
      place_ref(k, ic[0], ic[1], ic[2]);
      for (int j = 0; j < 4; j++) used[j] = 0;
      ok = 1;
      for (int i = 0; i < 4; i++) begin
        if (ok) begin
          found = 0;
          for (int j = 0; j < 4; j++) begin
            if (!found && !used[j] && a[i][3:0] == ref_atom[j][3:0]) begin
              dsq = 0;
              for (int q = 0; q < 3; q++) begin
                e = coord(a[i], q) - img[j][q];
                dsq += e * e;
              end
              if (dsq < longint'(tol_sq)) begin
                used[j] = 1;
                found = 1;
              end
            end
          end
          ok = found;
        end
      end
      if (ok) begin
        r.valid_mask[k] = 1'b1;
        r.match_cnt++;
      end
    end
    return r;
  endfunction

  function automatic longint rnd_signed(int span);
    return longint'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic logic [57:0] rnd_atom(int span, logic [3:0] sp);
    logic [17:0] x, y, z;
    x = 18'(rnd_signed(span));
    y = 18'(rnd_signed(span));
    z = 18'(rnd_signed(span));
    return {x, y, z, sp};
  endfunction

  // image of the reference under a random operation, shifted, jittered, shuffled;
  // a broken one gets a wrong species or one atom pushed far away
  function automatic in_item_t image_cluster(int noise, bit broken);
    logic [57:0] a [4];
    logic [57:0] t;
    logic [17:0] v [3];
    int          p, victim;
    place_ref($urandom_range(0, MAX_OPS - 1), rnd_signed(2000), rnd_signed(2000),
              rnd_signed(2000));
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 3; j++) v[j] = 18'(img[i][j] + rnd_signed(noise));
      a[i] = {v[0], v[1], v[2], ref_atom[i][3:0]};
    end
    for (int i = 3; i > 0; i--) begin
      p = $urandom_range(0, i);
      t = a[i]; a[i] = a[p]; a[p] = t;
    end
    if (broken) begin
      victim = $urandom_range(0, 3);
      if ($urandom_range(0, 1)) a[victim][3:0] = a[victim][3:0] + 4'd1;
      else a[victim][57:40] = a[victim][57:40] + 18'd2000;
    end
    return '{atom_0: a[0], atom_1: a[1], atom_2: a[2], atom_3: a[3]};
  endfunction

  function automatic in_item_t random_cluster();
    in_item_t     it;
    logic [255:0] raw;
    int           pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) it = image_cluster($urandom_range(0, 1) ? 60 : 250, 1'b0);
    else if (pick < 85) it = image_cluster(60, 1'b1);
    else begin
      raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
             $urandom};
      it = raw[$bits(in_item_t)-1:0];
    end
    return it;
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [57:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx < CFG_MATCH_TOL) ref_atom[idx[1:0]] = data;
    else if (idx == CFG_MATCH_TOL) tol_sq = data[TOLW-1:0];
  endtask

  task automatic send(in_item_t it, bit known, out_item_t res);
    int gap;
    @(negedge clk_i);
    start  <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (busy);
    pending_results.push_back(known ? res : match_ops(it));
    if ($urandom_range(0, 99) < idle_pct) begin
      gap = $urandom_range(1, 4);
      @(negedge clk_i);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  task automatic drain();
    @(negedge clk_i);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 2) @(posedge clk_i);
  endtask

  task automatic random_refs(bit one_species, int span);
    for (int i = 0; i < 4; i++)
      write_reg(3'(CFG_REF_POINT_0 + i),
                rnd_atom(span, one_species ? 4'd0 : 4'($urandom_range(0, 3))));
  endtask

  task automatic run_random(int count);
    for (int n = 0; n < count; n++) begin
      send(random_cluster(), 1'b0, '0);
      if (n == count / 2 && idle_pct != 0) drain();
    end
    drain();
  endtask

  always @(posedge clk_i) begin
    if (result_valid_o) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result mask=%h count=%0d", $time,
                 result_o.valid_mask, result_o.match_cnt);
        fail_cnt++;
      end else begin
        if (result_o.valid_mask !== pending_results[0].valid_mask) begin
          $display("%0t: valid_mask expected %h actual %h", $time,
                   pending_results[0].valid_mask, result_o.valid_mask);
          fail_cnt++;
        end
        if (result_o.match_cnt !== pending_results[0].match_cnt) begin
          $display("%0t: match count expected %0d actual %0d", $time,
                   pending_results[0].match_cnt, result_o.match_cnt);
          fail_cnt++;
        end
        void'(pending_results.pop_front());
      end
    end
  end

  initial begin
    #5ms;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    table_row_t  dir_rows [$];
    table_row_t  row;
    logic [57:0] hi_pt, lo_pt;
    hi_pt = {18'h1ffff, 18'h1ffff, 18'h1ffff, 4'd0};
    lo_pt = {18'h20000, 18'h20000, 18'h20000, 4'd0};
    for (int i = 0; i < 4; i++) ref_atom[i] = '0;
    tol_sq = TOL_RESET;

    // reset registers: all-zero reference of species 0 fits every operation
    dir_rows.push_back('{'0, 1, '{24'hffffff, 5'd24}});
    dir_rows.push_back('{'{hi_pt, hi_pt, hi_pt, hi_pt}, 1, '{24'hffffff, 5'd24}});
    dir_rows.push_back('{'{lo_pt, lo_pt, lo_pt, lo_pt}, 1, '{24'hffffff, 5'd24}});
    dir_rows.push_back('{'{58'h1, 58'h1, 58'h1, 58'h1}, 1, '{24'h0, 5'd0}});
    dir_rows.push_back('{'{58'hf, 58'hf, 58'hf, 58'hf}, 1, '{24'h0, 5'd0}});
    dir_rows.push_back('{'1, 0, '0});
    dir_rows.push_back('{'{hi_pt, lo_pt, hi_pt, lo_pt}, 0, '0});
    // single-atom offsets from the mean that stay inside the tolerance
    dir_rows.push_back('{'{58'd300 << 40, 58'd0, 58'd0, 58'd0}, 0, '0});
    dir_rows.push_back('{'{58'd400 << 40, 58'd0, 58'd0, 58'd0}, 0, '0});
    dir_rows.push_back('{'{58'd400 << 4, 58'd0, 58'd0, 58'd0}, 0, '0});

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[r]) begin
      row = dir_rows[r];
      send(row.it, row.known, row.res);
    end
    drain();
    // odd rounding halves: unit offsets against half coefficients
    write_reg(CFG_REF_POINT_1, {18'd1, 18'd3, 18'd0, 4'd0});
    write_reg(CFG_REF_POINT_2, {18'h3ffff, 18'd2, 18'd1, 4'd0});
    run_random(150);

    idle_pct = 50;
    random_refs(1'b0, 20000);
    run_random(220);

    idle_pct = 20;
    random_refs(1'b1, 20000);
    write_reg(CFG_MATCH_TOL, 58'd377488);
    run_random(220);

    // tolerance zero: nothing can match
    idle_pct = 0;
    write_reg(CFG_MATCH_TOL, 58'd0);
    run_random(120);

    // widest tolerance with junk above the register width, extreme reference
    idle_pct = 50;
    write_reg(CFG_MATCH_TOL, {34'h3ffffffff, 24'hffffff});
    write_reg(CFG_REF_POINT_0, {hi_pt[57:4], 4'd2});
    write_reg(CFG_REF_POINT_1, lo_pt);
    write_reg(CFG_REF_POINT_2, {18'h1ffff, 18'h20000, 18'h1ffff, 4'd2});
    write_reg(CFG_REF_POINT_3, {18'h20000, 18'h1ffff, 18'h20000, 4'd0});
    run_random(200);

    // unused index must change nothing
    idle_pct = 20;
    random_refs(1'b0, 4000);
    write_reg(CFG_MATCH_TOL, 58'($urandom_range(20000, 400000)));
    write_reg(CFG_IDX_UNUSED, '1);
    run_random(200);

    idle_pct = 0;
    random_refs(1'b0, 30000);
    write_reg(CFG_MATCH_TOL, 58'(TOL_RESET));
    run_random(180);

    if (fail_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
